>>> sv/trle_pkg.sv
// ----------------------------------------------------------------------------
// trle_pkg
// shared types and constants for the tga rle pixel decoder
// ----------------------------------------------------------------------------
package trle_pkg;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_HEADER   = 6'b000010,
    PH_SKIP_ID  = 6'b000100,
    PH_PACKET   = 6'b001000,
    PH_PIXEL    = 6'b010000,
    PH_FINISHED = 6'b100000
  } phase_t;

  localparam logic [1:0] KIND_RUN         = 2'd0;
  localparam logic [1:0] KIND_UNSUPPORTED = 2'd1;
  localparam logic [1:0] KIND_EMPTY       = 2'd2;

  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'd10;

  localparam logic [4:0] BPP_RGB  = 5'd3;
  localparam logic [4:0] BPP_RGBA = 5'd4;

  localparam logic [4:0] HDR_ID_LEN   = 5'd0;
  localparam logic [4:0] HDR_TYPE     = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH    = 5'd16;
  localparam logic [4:0] HDR_DESC     = 5'd17;
  localparam logic [4:0] HDR_END      = 5'd18;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] pixel_index;
    logic [7:0]  run_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        has_alpha;
    logic        origin_top_left;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        image_done;
  } result_t;

endpackage

>>> sv/trle_in_stage.sv
// ----------------------------------------------------------------------------
// trle_in_stage
// input register holding one byte item ahead of the decode logic
// ----------------------------------------------------------------------------
module trle_in_stage
  import trle_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     stage_valid,
  output in_item_t stage_item
);

  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_item;
    end
  end

endmodule

>>> sv/trle_core.sv
// ----------------------------------------------------------------------------
// trle_core
// header parse, packet and pixel decode state, one byte item per advance
// ----------------------------------------------------------------------------
module trle_core
  import trle_pkg::*;
#(
  parameter int PIXEL_COUNT_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     stage_valid,
  input  in_item_t stage_item,
  input  logic     advance,
  output logic     res_valid,
  output result_t  res
);

  localparam int PB = PIXEL_COUNT_BITS;

  phase_t          phase, phase_next;
  logic [4:0]      header_position, header_position_next;
  logic [7:0]      id_bytes_left, id_bytes_left_next;
  logic [7:0]      image_type, image_type_next;
  logic [15:0]     width_reg, width_reg_next;
  logic [15:0]     height_reg, height_reg_next;
  logic [4:0]      bytes_per_pixel, bytes_per_pixel_next;
  logic            top_origin_flag, top_origin_flag_next;
  logic [PB-1:0]   total, total_next;
  logic [PB-1:0]   pixels_done, pixels_done_next;
  logic [PB-1:0]   remaining, remaining_next;
  logic [7:0]      packet_pixels_left, packet_pixels_left_next;
  logic            packet_is_run, packet_is_run_next;
  logic [1:0]      byte_in_pixel, byte_in_pixel_next;
  logic [7:0]      colour [4];
  logic [7:0]      colour_next [4];

  phase_t          cur_phase;
  logic [4:0]      cur_pos;
  logic [7:0]      b;
  logic [31:0]     prod;
  logic [PB-1:0]   prod_sat;
  logic            is_rle;
  logic            four;
  logic            supported;
  logic [7:0]      len;
  logic [PB-1:0]   len_ext;
  logic [PB-1:0]   ppl_ext;
  logic            done;
  phase_t          data_phase;

  assign b          = stage_item.stream_byte;
  assign cur_phase  = stage_item.file_start ? PH_HEADER : phase;
  assign cur_pos    = stage_item.file_start ? 5'd0 : header_position;
  assign is_rle     = (image_type == TYPE_RLE);
  assign four       = (bytes_per_pixel == BPP_RGBA);
  assign data_phase = is_rle ? PH_PACKET : PH_PIXEL;
  assign supported  = (image_type == TYPE_RAW || image_type == TYPE_RLE) &&
                      (bytes_per_pixel == BPP_RGB || bytes_per_pixel == BPP_RGBA);

  assign prod = {16'd0, width_reg} * {16'd0, height_reg};
  always_comb begin
    if ((prod >> PB) != 32'd0) begin
      prod_sat = '1;
    end else begin
      prod_sat = prod[PB-1:0];
    end
  end

  assign ppl_ext = {{(PB-8){1'b0}}, packet_pixels_left};

  always_comb begin
    phase_next              = phase;
    header_position_next    = header_position;
    id_bytes_left_next      = id_bytes_left;
    image_type_next         = image_type;
    width_reg_next          = width_reg;
    height_reg_next         = height_reg;
    bytes_per_pixel_next    = bytes_per_pixel;
    top_origin_flag_next    = top_origin_flag;
    total_next              = total;
    pixels_done_next        = pixels_done;
    remaining_next          = remaining;
    packet_pixels_left_next = packet_pixels_left;
    packet_is_run_next      = packet_is_run;
    byte_in_pixel_next      = byte_in_pixel;
    colour_next             = colour;
    len                     = 8'd1;
    len_ext                 = '0;
    done                    = 1'b0;
    res_valid               = 1'b0;
    res                     = '0;

    if (stage_item.file_start) begin
      phase_next = PH_HEADER;
    end

    case (cur_phase)
      PH_HEADER: begin
        case (cur_pos)
          HDR_ID_LEN:    id_bytes_left_next = b;
          HDR_TYPE:      image_type_next = b;
          HDR_WIDTH_LO:  width_reg_next[7:0] = b;
          HDR_WIDTH_HI:  width_reg_next[15:8] = b;
          HDR_HEIGHT_LO: height_reg_next[7:0] = b;
          HDR_HEIGHT_HI: height_reg_next[15:8] = b;
          HDR_DEPTH: begin
            bytes_per_pixel_next = b[7:3];
            total_next           = prod_sat;
          end
          HDR_DESC:      top_origin_flag_next = b[5];
          default:       ;
        endcase
        if (cur_pos < HDR_DESC) begin
          header_position_next = cur_pos + 5'd1;
        end else begin
          header_position_next    = HDR_END;
          pixels_done_next        = '0;
          remaining_next          = total;
          packet_pixels_left_next = 8'd0;
          packet_is_run_next      = 1'b0;
          byte_in_pixel_next      = 2'd0;
          res.origin_top_left     = b[5];
          res.image_width         = width_reg;
          res.image_height        = height_reg;
          res.image_done          = 1'b1;
          if (!supported) begin
            phase_next      = PH_FINISHED;
            res_valid       = 1'b1;
            res.result_kind = KIND_UNSUPPORTED;
          end else if (width_reg == 16'd0 || height_reg == 16'd0) begin
            phase_next      = PH_FINISHED;
            res_valid       = 1'b1;
            res.result_kind = KIND_EMPTY;
            res.has_alpha   = four;
          end else if (id_bytes_left != 8'd0) begin
            phase_next = PH_SKIP_ID;
          end else begin
            phase_next = data_phase;
          end
        end
      end
      PH_SKIP_ID: begin
        id_bytes_left_next = id_bytes_left - 8'd1;
        if (id_bytes_left == 8'd1) begin
          phase_next = data_phase;
        end
      end
      PH_PACKET: begin
        packet_pixels_left_next = {1'b0, b[6:0]} + 8'd1;
        packet_is_run_next      = b[7];
        byte_in_pixel_next      = 2'd0;
        phase_next              = PH_PIXEL;
      end
      PH_PIXEL: begin
        colour_next[byte_in_pixel] = b;
        if ({3'd0, byte_in_pixel} + 5'd1 < bytes_per_pixel) begin
          byte_in_pixel_next = byte_in_pixel + 2'd1;
        end else begin
          byte_in_pixel_next = 2'd0;
          if (is_rle && packet_is_run) begin
            if (remaining < ppl_ext) begin
              len = remaining[7:0];
            end else begin
              len = packet_pixels_left;
            end
            packet_pixels_left_next = 8'd0;
          end else begin
            len = 8'd1;
            if (is_rle && packet_pixels_left != 8'd0) begin
              packet_pixels_left_next = packet_pixels_left - 8'd1;
            end
          end
          len_ext          = {{(PB-8){1'b0}}, len};
          pixels_done_next = pixels_done + len_ext;
          remaining_next   = remaining - len_ext;
          done             = (remaining == len_ext);
          if (done) begin
            phase_next = PH_FINISHED;
          end else if (is_rle && packet_pixels_left_next == 8'd0) begin
            phase_next = PH_PACKET;
          end
          res_valid           = 1'b1;
          res.result_kind     = KIND_RUN;
          res.pixel_index     = 32'(pixels_done);
          res.run_length      = len;
          res.red             = colour_next[2];
          res.green           = colour_next[1];
          res.blue            = colour_next[0];
          res.alpha           = four ? colour_next[3] : 8'd0;
          res.has_alpha       = four;
          res.origin_top_left = top_origin_flag;
          res.image_width     = width_reg;
          res.image_height    = height_reg;
          res.image_done      = done;
        end
      end
      default: ;
    endcase

    if (!stage_valid) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      header_position    <= 5'd0;
      id_bytes_left      <= 8'd0;
      image_type         <= 8'd0;
      width_reg          <= 16'd0;
      height_reg         <= 16'd0;
      bytes_per_pixel    <= 5'd0;
      top_origin_flag    <= 1'b0;
      total              <= '0;
      pixels_done        <= '0;
      remaining          <= '0;
      packet_pixels_left <= 8'd0;
      packet_is_run      <= 1'b0;
      byte_in_pixel      <= 2'd0;
    end else if (advance) begin
      phase              <= phase_next;
      header_position    <= header_position_next;
      id_bytes_left      <= id_bytes_left_next;
      image_type         <= image_type_next;
      width_reg          <= width_reg_next;
      height_reg         <= height_reg_next;
      bytes_per_pixel    <= bytes_per_pixel_next;
      top_origin_flag    <= top_origin_flag_next;
      total              <= total_next;
      pixels_done        <= pixels_done_next;
      remaining          <= remaining_next;
      packet_pixels_left <= packet_pixels_left_next;
      packet_is_run      <= packet_is_run_next;
      byte_in_pixel      <= byte_in_pixel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      colour <= colour_next;
    end
  end

endmodule

>>> sv/trle_out_reg.sv
// ----------------------------------------------------------------------------
// trle_out_reg
// result register holding one item until the receiver takes it
// ----------------------------------------------------------------------------
module trle_out_reg
  import trle_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= res;
    end
  end

endmodule

>>> sv/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// streaming decoder for true-color tga files, raw and rle, 24 and 32 bit
// ----------------------------------------------------------------------------
// the file arrives up to one byte item per cycle on the in channel (in_valid,
// in_ready, stream_byte, file_start); file_start marks header byte 0 and
// restarts parsing at any time. after the 18-byte header and the id field,
// each completed pixel or rle run produces one item on the out channel:
// the run color in rgb(a) order, its file-order start index and length.
// unsupported type or depth and empty images give a single item instead.
// an accepted byte sits in the input register, and the decode logic loads
// its result into the result register when the byte advances. throughput is
// one byte per cycle unless a result waits on a stalled receiver; every byte
// only updates small counters, and the pixel count comes from one 16x16
// multiply registered at header byte 16. a stalled receiver holds the result
// register; bytes that produce no result still pass, and one more byte waits
// in the input register before in_ready drops. reset empties both registers
// and returns the parser to waiting for a file start; bytes before any file
// start are dropped.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder
  import trle_pkg::*;
#(
  parameter int PIXEL_COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        file_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [31:0] pixel_index,
  output logic [7:0]  run_length,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        has_alpha,
  output logic        origin_top_left,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic        image_done
);

  in_item_t in_item;
  in_item_t stage_item;
  logic     stage_valid;
  logic     advance;
  logic     res_valid;
  result_t  res;
  result_t  out_item;

  assign in_item.stream_byte = stream_byte;
  assign in_item.file_start  = file_start;

  assign advance = stage_valid && (!res_valid || !out_valid || out_ready);

  trle_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  trle_core #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .advance     (advance),
    .res_valid   (res_valid),
    .res         (res)
  );

  trle_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign result_kind     = out_item.result_kind;
  assign pixel_index     = out_item.pixel_index;
  assign run_length      = out_item.run_length;
  assign red             = out_item.red;
  assign green           = out_item.green;
  assign blue            = out_item.blue;
  assign alpha           = out_item.alpha;
  assign has_alpha       = out_item.has_alpha;
  assign origin_top_left = out_item.origin_top_left;
  assign image_width     = out_item.image_width;
  assign image_height    = out_item.image_height;
  assign image_done      = out_item.image_done;

endmodule

>>> sv/trle_checker.sv
// ----------------------------------------------------------------------------
// trle_checker
// port-level checks on the decoder result channel
// ----------------------------------------------------------------------------
module trle_checker
  import trle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  result_kind,
  input  logic [7:0]  run_length,
  input  logic [7:0]  alpha,
  input  logic        has_alpha,
  input  logic        image_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
      $stable(run_length) && $stable(image_done))
    else $error("result changed while stalled");

  a_non_run_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_RUN |-> run_length == 8'd0 && image_done)
    else $error("error or empty item not final or has length");

  a_run_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_RUN |-> run_length != 8'd0 &&
      run_length <= 8'd128)
    else $error("run length out of range");

  a_alpha_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_alpha |-> alpha == 8'd0)
    else $error("alpha set without alpha channel");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_kind == KIND_RUN || result_kind == KIND_UNSUPPORTED ||
      result_kind == KIND_EMPTY)
    else $error("bad result kind");

endmodule

bind tga_rle_pixel_decoder trle_checker u_trle_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_kind (result_kind),
  .run_length  (run_length),
  .alpha       (alpha),
  .has_alpha   (has_alpha),
  .image_done  (image_done)
);

>>> tb/sv/trle_run_checker.sv
// ----------------------------------------------------------------------------
// trle_run_checker
// watches both channels of the tga rle pixel decoder, decodes every accepted
// byte item on its own to work out the expected result items, and compares each
// accepted result item field by field with the oldest expected one
// ----------------------------------------------------------------------------
module trle_run_checker
  import trle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        file_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  result_kind,
  input  logic [31:0] pixel_index,
  input  logic [7:0]  run_length,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  input  logic        has_alpha,
  input  logic        origin_top_left,
  input  logic [15:0] image_width,
  input  logic [15:0] image_height,
  input  logic        image_done,
  output int          fail_count,
  output int          runs_waiting,
  output int          runs_checked
);

  phase_t      phase;
  logic [4:0]  hdr_pos;
  logic [7:0]  id_left;
  logic [7:0]  img_type;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [4:0]  bpp;
  logic        top_flag;
  logic [31:0] pix_done;
  logic [7:0]  pkt_left;
  logic        pkt_run;
  logic [1:0]  byte_pos;
  logic [7:0]  color [4];

  result_t     expected_runs [$];
  result_t     want;
  int          errors = 0;
  int          checked = 0;
  int          errors_q = 0;
  int          waiting_q = 0;
  int          checked_q = 0;

  assign fail_count   = errors_q;
  assign runs_waiting = waiting_q;
  assign runs_checked = checked_q;

  task automatic clear_state();
    phase    = PH_IDLE;
    hdr_pos  = '0;
    id_left  = '0;
    img_type = '0;
    img_w    = '0;
    img_h    = '0;
    bpp      = '0;
    top_flag = 1'b0;
    pix_done = '0;
    pkt_left = '0;
    pkt_run  = 1'b0;
    byte_pos = '0;
    foreach (color[i]) color[i] = '0;
  endtask

  function automatic logic [31:0] pixel_total();
    return {16'd0, img_w} * {16'd0, img_h};
  endfunction

  function automatic phase_t data_phase();
    return (img_type == TYPE_RLE) ? PH_PACKET : PH_PIXEL;
  endfunction

  function automatic result_t make_result(logic [1:0] kind, logic [31:0] index,
                                          logic [7:0] len, logic with_color,
                                          logic done);
    result_t r;
    logic    four;
    four              = (bpp == BPP_RGBA);
    r.result_kind     = kind;
    r.pixel_index     = index;
    r.run_length      = len;
    r.red             = with_color ? color[2] : 8'd0;
    r.green           = with_color ? color[1] : 8'd0;
    r.blue            = with_color ? color[0] : 8'd0;
    r.alpha           = (with_color && four) ? color[3] : 8'd0;
    r.has_alpha       = (kind == KIND_UNSUPPORTED) ? 1'b0 : four;
    r.origin_top_left = top_flag;
    r.image_width     = img_w;
    r.image_height    = img_h;
    r.image_done      = done;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic s);
    logic [31:0] total;
    logic [31:0] remaining;
    logic [31:0] len;
    logic [31:0] index;
    logic        done;
    if (s) begin
      clear_state();
      phase = PH_HEADER;
    end
    case (phase)
      PH_HEADER: begin
        case (hdr_pos)
          HDR_ID_LEN:    id_left = b;
          HDR_TYPE:      img_type = b;
          HDR_WIDTH_LO:  img_w[7:0] = b;
          HDR_WIDTH_HI:  img_w[15:8] = b;
          HDR_HEIGHT_LO: img_h[7:0] = b;
          HDR_HEIGHT_HI: img_h[15:8] = b;
          HDR_DEPTH:     bpp = b[7:3];
          HDR_DESC:      top_flag = b[5];
          default: ;
        endcase
        if (hdr_pos < HDR_DESC) begin
          hdr_pos = hdr_pos + 5'd1;
        end else begin
          hdr_pos = HDR_END;
          if (!((img_type == TYPE_RAW || img_type == TYPE_RLE) &&
                (bpp == BPP_RGB || bpp == BPP_RGBA))) begin
            phase = PH_FINISHED;
            expected_runs.push_back(make_result(KIND_UNSUPPORTED, '0, '0, 1'b0, 1'b1));
          end else if (pixel_total() == 32'd0) begin
            phase = PH_FINISHED;
            expected_runs.push_back(make_result(KIND_EMPTY, '0, '0, 1'b0, 1'b1));
          end else begin
            phase = (id_left != 8'd0) ? PH_SKIP_ID : data_phase();
          end
        end
      end
      PH_SKIP_ID: begin
        id_left = id_left - 8'd1;
        if (id_left == 8'd0) phase = data_phase();
      end
      PH_PACKET: begin
        pkt_left = {1'b0, b[6:0]} + 8'd1;
        pkt_run  = b[7];
        byte_pos = 2'd0;
        phase    = PH_PIXEL;
      end
      PH_PIXEL: begin
        color[byte_pos] = b;
        if ({3'd0, byte_pos} + 5'd1 < bpp) begin
          byte_pos = byte_pos + 2'd1;
        end else begin
          byte_pos  = 2'd0;
          total     = pixel_total();
          remaining = (pix_done < total) ? total - pix_done : 32'd0;
          if (img_type == TYPE_RLE && pkt_run) begin
            len = {24'd0, pkt_left};
            if (len > remaining) len = remaining;
            pkt_left = 8'd0;
          end else begin
            len = 32'd1;
            if (img_type == TYPE_RLE && pkt_left != 8'd0) pkt_left = pkt_left - 8'd1;
          end
          index    = pix_done;
          pix_done = pix_done + len;
          done     = (pix_done >= total);
          if (done) phase = PH_FINISHED;
          else if (img_type == TYPE_RLE && pkt_left == 8'd0) phase = PH_PACKET;
          expected_runs.push_back(make_result(KIND_RUN, index, len[7:0], 1'b1, done));
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_runs.delete();
    end else begin
      if (in_valid && in_ready) decode_byte(stream_byte, file_start);
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          $error("result item arrived with none expected");
          errors++;
        end else begin
          want = expected_runs.pop_front();
          check_field("result_kind", want.result_kind, result_kind);
          check_field("pixel_index", want.pixel_index, pixel_index);
          check_field("run_length", want.run_length, run_length);
          check_field("red", want.red, red);
          check_field("green", want.green, green);
          check_field("blue", want.blue, blue);
          check_field("alpha", want.alpha, alpha);
          check_field("has_alpha", want.has_alpha, has_alpha);
          check_field("origin_top_left", want.origin_top_left, origin_top_left);
          check_field("image_width", want.image_width, image_width);
          check_field("image_height", want.image_height, image_height);
          check_field("image_done", want.image_done, image_done);
          checked++;
        end
      end
    end
    errors_q  <= errors;
    waiting_q <= expected_runs.size();
    checked_q <= checked;
  end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives tga byte streams into the rle pixel decoder: a few hand-made files
// for the corner cases, then random raw and rle files with truncations,
// broken headers and trailing noise, under three sender/receiver stall mixes
// ----------------------------------------------------------------------------
module testbench
  import trle_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  stream_byte;
  logic        file_start;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [31:0] pixel_index;
  logic [7:0]  run_length;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        has_alpha;
  logic        origin_top_left;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        image_done;

  int          fail_count;
  int          runs_waiting;
  int          runs_checked;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          live_bytes = 0;
  int          files_sent = 0;
  logic [7:0]  file_body [$];

  always #10 clk = ~clk;

  tga_rle_pixel_decoder dut (.*);

  trle_run_checker run_check (.*);

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic send_byte(input logic [7:0] b, input logic s, input bit live);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    stream_byte = b;
    file_start  = s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (live) live_bytes++;
  endtask

  task automatic send_header(input logic [7:0] id_len, input logic [7:0] typ,
                             input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] depth, input logic [7:0] desc);
    logic [7:0] hdr [18];
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[HDR_ID_LEN]    = id_len;
    hdr[HDR_TYPE]      = typ;
    hdr[HDR_WIDTH_LO]  = w[7:0];
    hdr[HDR_WIDTH_HI]  = w[15:8];
    hdr[HDR_HEIGHT_LO] = h[7:0];
    hdr[HDR_HEIGHT_HI] = h[15:8];
    hdr[HDR_DEPTH]     = depth;
    hdr[HDR_DESC]      = desc;
    files_sent++;
    for (int i = 0; i < 18; i++) send_byte(hdr[i], i == 0, 1'b1);
  endtask

  task automatic random_file();
    int         pick;
    int         w;
    int         h;
    int         goal;
    int         covered;
    int         cnt;
    int         k;
    int         keep;
    logic [4:0] bpp;
    logic [7:0] typ;
    logic [7:0] depth;
    logic [7:0] idl;
    logic [7:0] pkt;
    file_body.delete();
    pick = $urandom_range(99);
    idl  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    typ  = $urandom_range(1) ? TYPE_RLE : TYPE_RAW;
    bpp  = $urandom_range(1) ? BPP_RGBA : BPP_RGB;
    if (pick < 8) begin
      // unsupported type or depth
      if ($urandom_range(1)) begin
        do begin
          typ = 8'($urandom);
        end while (typ == TYPE_RAW || typ == TYPE_RLE);
        depth = 8'($urandom);
      end else begin
        do begin
          depth = 8'($urandom);
        end while (depth[7:3] == BPP_RGB || depth[7:3] == BPP_RGBA);
      end
      send_header(idl, typ, 16'($urandom), 16'($urandom), depth, 8'($urandom));
      repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0, 1'b0);
    end else if (pick < 13) begin
      // empty image
      if ($urandom_range(1)) begin
        w = 0;
        h = $urandom_range(65535);
      end else begin
        w = $urandom_range(65535);
        h = 0;
      end
      send_header(idl, typ, 16'(w), 16'(h), {bpp, 3'($urandom)}, 8'($urandom));
      repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0, 1'b0);
    end else if (pick < 18) begin
      // broken header cut short by the next file
      cnt = $urandom_range(17, 1);
      files_sent++;
      send_byte(8'($urandom), 1'b1, 1'b1);
      repeat (cnt - 1) send_byte(8'($urandom), 1'b0, 1'b1);
    end else begin
      depth = {bpp, 3'($urandom)};
      if ($urandom_range(19) == 0) begin
        w    = $urandom_range(65535, 256);
        h    = $urandom_range(65535, 256);
        goal = $urandom_range(20, 1);
      end else begin
        w    = $urandom_range(6, 1);
        h    = $urandom_range(4, 1);
        goal = w * h;
      end
      repeat (idl) file_body.push_back(8'($urandom));
      covered = 0;
      while (covered < goal) begin
        if (typ == TYPE_RLE) begin
          cnt = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(3);
          pkt = {1'($urandom), 7'(cnt)};
          file_body.push_back(pkt);
          if (pkt[7]) begin
            repeat (bpp) file_body.push_back(8'($urandom));
            covered += cnt + 1;
          end else begin
            for (k = 0; k <= cnt && covered < goal; k++) begin
              repeat (bpp) file_body.push_back(8'($urandom));
              covered++;
            end
          end
        end else begin
          repeat (bpp) file_body.push_back(8'($urandom));
          covered++;
        end
      end
      keep = ($urandom_range(9) == 0) ? $urandom_range(file_body.size())
                                      : file_body.size();
      send_header(idl, typ, 16'(w), 16'(h), depth, 8'($urandom));
      for (k = 0; k < keep; k++) send_byte(file_body[k], 1'b0, 1'b1);
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  initial begin
    int target;
    int n;
    in_valid    = 1'b0;
    stream_byte = 8'd0;
    file_start  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 11;
    recv_idle_pct = 78;

    // bytes before any file start
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    // unsupported type, unsupported depths
    send_header(8'd0, 8'd3, 16'd4, 16'd4, 8'd24, 8'h00);
    send_header(8'd0, TYPE_RAW, 16'd1, 16'd1, 8'd16, 8'hff);
    send_header(8'd0, TYPE_RLE, 16'hffff, 16'hffff, 8'hff, 8'h20);
    // empty images, then bytes after the image
    send_header(8'd3, TYPE_RLE, 16'd0, 16'd5, 8'd32, 8'h20);
    send_byte(8'h80, 1'b0, 1'b0);
    send_header(8'd0, TYPE_RAW, 16'd5, 16'd0, 8'd24, 8'h00);
    // raw with id field and extreme colors
    send_header(8'd2, TYPE_RAW, 16'd2, 16'd1, 8'd24, 8'h20);
    send_byte(8'haa, 1'b0, 1'b1);
    send_byte(8'h55, 1'b0, 1'b1);
    repeat (3) send_byte(8'h00, 1'b0, 1'b1);
    repeat (3) send_byte(8'hff, 1'b0, 1'b1);
    send_byte(8'h12, 1'b0, 1'b0);
    // rle run clamped to the pixels left
    send_header(8'd0, TYPE_RLE, 16'd3, 16'd1, 8'd32, 8'h00);
    send_byte(8'hff, 1'b0, 1'b1);
    repeat (4) send_byte(8'($urandom), 1'b0, 1'b1);
    // raw packet reaching the last pixel
    send_header(8'd1, TYPE_RLE, 16'd2, 16'd2, 8'd24, 8'hdf);
    send_byte(8'h3c, 1'b0, 1'b1);
    send_byte(8'h7f, 1'b0, 1'b1);
    repeat (12) send_byte(8'($urandom), 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b0);
    // single run then a two pixel raw packet
    send_header(8'd0, TYPE_RLE, 16'd3, 16'd1, 8'd39, 8'h00);
    send_byte(8'h80, 1'b0, 1'b1);
    repeat (4) send_byte(8'($urandom), 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b1);
    repeat (8) send_byte(8'($urandom), 1'b0, 1'b1);
    // largest image, dropped by a file start mid-image and mid-header
    send_header(8'd1, TYPE_RAW, 16'hffff, 16'hffff, 8'd32, 8'h20);
    repeat (9) send_byte(8'($urandom), 1'b0, 1'b1);
    files_sent++;
    send_byte(8'h00, 1'b1, 1'b1);
    repeat (6) send_byte(8'($urandom), 1'b0, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 78 : 0;
      recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 11 : 0;
      target = 450 * (ph + 1);
      while (live_bytes < target) random_file();
    end
    in_valid = 1'b0;

    for (n = 0; n < 20000 && runs_waiting != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d files sent, %0d decoded stream bytes, %0d result items compared",
             files_sent, live_bytes, runs_checked);
    $display("stall mixes: sender light/receiver heavy, reversed, then none");
    if (fail_count == 0 && runs_waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
